// ===== design/file_uri_to_path_decoder_top_defines.svh =====
// assertion macros for the checker file of the uri decoder
// depends on a clk and an active-low rst_n in the scope that uses them
`ifndef FILE_URI_TO_PATH_DECODER_TOP_DEFINES_SVH
`define FILE_URI_TO_PATH_DECODER_TOP_DEFINES_SVH

// same-cycle implication
`define FUD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FUD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/fud_pkg.sv =====
// types, character constants and helper functions of the file uri decoder
// no dependencies
package fud_pkg;

    typedef enum logic [2:0] {
        PH_PREFIX = 3'd0,
        PH_REJECT = 3'd1,
        PH_AUTH   = 3'd2,
        PH_DRIVE  = 3'd3,
        PH_BODY   = 3'd4
    } phase_t;

    localparam int unsigned PREFIX_LEN = 7;
    localparam int unsigned MAX_RES    = 5;
    localparam int unsigned RES_W      = $clog2(MAX_RES + 1);

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [4:0] NOT_HEX  = 5'd16;

    typedef struct packed {
        phase_t      phase;
        logic [2:0]  prefix_pos;
        logic [1:0]  wcount;
    } ctrl_t;

    typedef logic [2:0][7:0] window_t;

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       last;
        logic       status;
    } result_t;

    typedef result_t [MAX_RES-1:0] bundle_t;

    // "file://"
    function automatic logic [7:0] scheme_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h66;
            3'd1:    c = 8'h69;
            3'd2:    c = 8'h6C;
            3'd3:    c = 8'h65;
            3'd4:    c = CH_COLON;
            3'd5:    c = CH_SLASH;
            3'd6:    c = CH_SLASH;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        if (c >= 8'h30 && c <= 8'h39)
            v = 5'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66)
            v = 5'(c - 8'h57);
        else if (c >= 8'h41 && c <= 8'h46)
            v = 5'(c - 8'h37);
        else
            v = NOT_HEX;
        return v;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

endpackage

// ===== design/file_uri_to_path_decoder_top.sv =====
// file uri to path decoder: input register, one-pass decode, result bundle register
// an item waits in the input register until its results can load the result register
// throughput: one item per cycle while m_tready is high and each item yields at most one
// result; an item with more results stalls until all are taken (up to four at a close)
// reset: asynchronous active-low rst_n clears the prefix match, window fill and all valids
// depends on fud_pkg and fud_step
module file_uri_to_path_decoder_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // end_of_uri
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [0] has_byte, [1] status
    output logic       m_tlast    // last
);
    import fud_pkg::*;

    logic             s1_valid_reg;
    logic [7:0]       s1_byte_reg;
    logic             s1_end_reg;

    ctrl_t            ctrl_reg;
    ctrl_t            ctrl_next;
    window_t          window_reg;
    window_t          window_next;

    bundle_t          step_res;
    logic [RES_W-1:0] step_cnt;

    logic             s2_valid_reg;
    bundle_t          bundle_reg;
    logic [RES_W-1:0] bcnt_reg;
    logic [RES_W-1:0] idx_reg;

    logic             s2_done;
    logic             s2_free;
    logic             s1_adv;
    result_t          cur;

    fud_step u_step (
        .ctrl        (ctrl_reg),
        .window      (window_reg),
        .in_byte     (s1_byte_reg),
        .end_of_uri  (s1_end_reg),
        .ctrl_next   (ctrl_next),
        .window_next (window_next),
        .results     (step_res),
        .res_count   (step_cnt)
    );

    assign s2_done  = s2_valid_reg && m_tready && (idx_reg == bcnt_reg - 1'b1);
    assign s2_free  = !s2_valid_reg || s2_done;
    // items with no result pass without waiting for the result register
    assign s1_adv   = s1_valid_reg && (step_cnt == '0 || s2_free);
    assign s_tready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_tready)
            s1_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_byte_reg <= s_tdata;
            s1_end_reg  <= s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctrl_reg <= '{phase: PH_PREFIX, prefix_pos: 3'd0, wcount: 2'd0};
        else if (s1_adv)
            ctrl_reg <= ctrl_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
            window_reg <= window_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            bcnt_reg     <= '0;
            idx_reg      <= '0;
        end
        else if (s1_adv && step_cnt != '0)
        begin
            s2_valid_reg <= 1'b1;
            bcnt_reg     <= step_cnt;
            idx_reg      <= '0;
        end
        else if (s2_done)
            s2_valid_reg <= 1'b0;
        else if (s2_valid_reg && m_tready)
            idx_reg <= idx_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && step_cnt != '0)
            bundle_reg <= step_res;
    end

    assign cur      = bundle_reg[idx_reg];
    assign m_tvalid = s2_valid_reg;
    assign m_tdata  = cur.data;
    assign m_tuser  = {cur.status, cur.has};
    assign m_tlast  = cur.last;

endmodule

// ===== design/fud_step.sv =====
// next-state and result logic for one uri item
// depends on fud_pkg
module fud_step (
    input  fud_pkg::ctrl_t               ctrl,
    input  fud_pkg::window_t             window,
    input  logic [7:0]                   in_byte,
    input  logic                         end_of_uri,
    output fud_pkg::ctrl_t               ctrl_next,
    output fud_pkg::window_t             window_next,
    output fud_pkg::bundle_t             results,
    output logic [fud_pkg::RES_W-1:0]    res_count
);
    import fud_pkg::*;

    always_comb
    begin
        window_t          w;
        logic [1:0]       wc;
        ctrl_t            c;
        bundle_t          r;
        logic [RES_W-1:0] n;
        logic             stop;
        logic             decided;
        logic             keep;
        logic [4:0]       hi;
        logic [4:0]       lo;

        w       = window;
        wc      = ctrl.wcount;
        c       = ctrl;
        r       = '0;
        n       = '0;
        stop    = 1'b0;
        decided = 1'b0;
        keep    = 1'b0;
        hi      = '0;
        lo      = '0;

        if (end_of_uri || in_byte == 8'h00)
        begin
            if (ctrl.phase == PH_DRIVE)
            begin
                r[n] = '{data: CH_SLASH, has: 1'b1, last: 1'b0, status: 1'b0};
                n = n + 1'b1;
            end
            if (ctrl.phase == PH_DRIVE || ctrl.phase == PH_BODY)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (2'(i) < wc)
                    begin
                        r[n] = '{data: w[i], has: 1'b1, last: 1'b0, status: 1'b0};
                        n = n + 1'b1;
                    end
                end
            end
            r[n] = '{data: 8'h00, has: 1'b0, last: 1'b1,
                     status: (ctrl.phase == PH_PREFIX || ctrl.phase == PH_REJECT)};
            n = n + 1'b1;
            c  = '{phase: PH_PREFIX, prefix_pos: 3'd0, wcount: 2'd0};
            wc = 2'd0;
        end
        else
        begin
            case (ctrl.phase)
                PH_PREFIX:
                begin
                    if (ctrl.prefix_pos < 3'(PREFIX_LEN) && in_byte == scheme_char(ctrl.prefix_pos))
                    begin
                        c.prefix_pos = ctrl.prefix_pos + 1'b1;
                        if (c.prefix_pos == 3'(PREFIX_LEN))
                            c.phase = PH_AUTH;
                    end
                    else
                        c.phase = PH_REJECT;
                end
                PH_AUTH:
                begin
                    if (in_byte == CH_SLASH)
                    begin
                        c.phase = PH_DRIVE;
                        wc = 2'd0;
                    end
                end
                PH_DRIVE, PH_BODY:
                begin
                    if (wc != 2'd3)
                    begin
                        w[wc] = in_byte;
                        wc = wc + 1'b1;
                    end
                    if (ctrl.phase == PH_BODY)
                        decided = 1'b1;
                    else if (!is_letter(w[0]))
                    begin
                        decided = 1'b1;
                        keep    = 1'b1;
                    end
                    else if (wc >= 2'd2)
                    begin
                        if (w[1] == CH_COLON)
                            decided = 1'b1;
                        else if (w[1] != CH_PCT)
                        begin
                            decided = 1'b1;
                            keep    = 1'b1;
                        end
                        else if (wc == 2'd3)
                        begin
                            decided = 1'b1;
                            keep    = (w[2] != CH_THREE);
                        end
                    end
                    if (decided)
                    begin
                        // drive root slash goes out only when no drive letter follows
                        if (keep)
                        begin
                            r[n] = '{data: CH_SLASH, has: 1'b1, last: 1'b0, status: 1'b0};
                            n = n + 1'b1;
                        end
                        c.phase = PH_BODY;
                        // emit every pending byte whose meaning is settled
                        for (int k = 0; k < 3; k++)
                        begin
                            if (!stop && wc != 2'd0)
                            begin
                                hi = hex_val(w[1]);
                                lo = hex_val(w[2]);
                                if (w[0] != CH_PCT ||
                                    (wc >= 2'd2 && hi == NOT_HEX) ||
                                    (wc == 2'd3 && lo == NOT_HEX))
                                begin
                                    r[n] = '{data: w[0], has: 1'b1, last: 1'b0, status: 1'b0};
                                    n = n + 1'b1;
                                    w[0] = w[1];
                                    w[1] = w[2];
                                    wc   = wc - 1'b1;
                                end
                                else if (wc == 2'd3)
                                begin
                                    r[n] = '{data: {hi[3:0], lo[3:0]}, has: 1'b1,
                                             last: 1'b0, status: 1'b0};
                                    n = n + 1'b1;
                                    wc = 2'd0;
                                end
                                else
                                    stop = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                    // rejected uri: bytes ignored until the close
                end
            endcase
        end

        c.wcount    = wc;
        ctrl_next   = c;
        window_next = w;
        results     = r;
        res_count   = n;
    end

endmodule

// ===== design/fud_checker.sv =====
// port-level checks on the result stream of the uri decoder, bound to the top level
// depends on file_uri_to_path_decoder_top_defines.svh
`include "file_uri_to_path_decoder_top_defines.svh"

module fud_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    // a stalled item holds
    `FUD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result changed while stalled")

    // the closing item carries no byte
    `FUD_ASSERT_NOW(a_last_no_byte, m_tvalid && m_tlast, !m_tuser[0] && m_tdata == 8'h00, "last item carries a byte")

    // every other item is a path byte with clear status
    `FUD_ASSERT_NOW(a_data_item, m_tvalid && !m_tlast, m_tuser[0] && !m_tuser[1], "data item without byte or with status")

    // status 1 only ever closes a uri
    `FUD_ASSERT_NOW(a_status_last, m_tvalid && m_tuser[1], m_tlast, "status set on a data item")

endmodule

bind file_uri_to_path_decoder_top fud_checker u_fud_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// testbench of file_uri_to_path_decoder_top: directed and random file uris on the input stream
// results are checked against an in-bench decoder model; depends on fud_pkg and the design files
module testbench;
    import fud_pkg::*;

    localparam int RANDOM_ITEMS   = 110;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    file_uri_to_path_decoder_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // decoder model state
    phase_t     uri_phase;
    int         scheme_pos;
    logic [7:0] look [0:2];
    int         look_n;
    string      scheme_str = "file://";

    result_t    path_q [$];
    int         errors;
    int         items_sent;
    int         results_seen;
    int         uris_closed;
    int         uris_rejected;
    int         stall_cycles;
    bit         tx_calm;
    bit         rx_calm;

    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] v;
        v = NOT_HEX;
        if (c >= "0" && c <= "9")
            v = 5'(c - "0");
        else if (c >= "a" && c <= "f")
            v = 5'(c - "a" + 10);
        else if (c >= "A" && c <= "F")
            v = 5'(c - "A" + 10);
        return v;
    endfunction

    function automatic bit alpha(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    task automatic clear_uri_state();
        uri_phase  = PH_PREFIX;
        scheme_pos = 0;
        look_n     = 0;
    endtask

    task automatic expect_res(input logic [7:0] b, input logic has, input logic last,
                              input logic status);
        result_t r;
        r.data   = b;
        r.has    = has;
        r.last   = last;
        r.status = status;
        path_q.push_back(r);
    endtask

    task automatic expect_byte(input logic [7:0] b);
        expect_res(b, 1'b1, 1'b0, 1'b0);
    endtask

    task automatic shift_look();
        look[0] = look[1];
        look[1] = look[2];
        if (look_n > 0)
            look_n--;
    endtask

    // send every pending byte whose meaning is already known
    task automatic settle_look();
        bit         done;
        logic [4:0] hi;
        logic [4:0] lo;
        done = 1'b0;
        while (!done && look_n > 0)
        begin
            hi = hex_nibble(look[1]);
            lo = hex_nibble(look[2]);
            if (look[0] != CH_PCT)
            begin
                expect_byte(look[0]);
                shift_look();
            end
            else if (look_n >= 2 && hi == NOT_HEX)
            begin
                expect_byte(CH_PCT);
                shift_look();
            end
            else if (look_n >= 3)
            begin
                if (lo != NOT_HEX)
                begin
                    expect_byte({hi[3:0], lo[3:0]});
                    look_n = 0;
                end
                else
                begin
                    expect_byte(CH_PCT);
                    shift_look();
                end
            end
            else
                done = 1'b1;
        end
    endtask

    task automatic spill_look();
        for (int i = 0; i < look_n; i++)
            expect_byte(look[i]);
        look_n = 0;
    endtask

    task automatic decode_item(input logic [7:0] b, input logic close);
        logic status;
        bit   decided;
        bit   keep_slash;
        decided    = 1'b0;
        keep_slash = 1'b0;
        if (close || b == 8'h00)
        begin
            status = 1'b0;
            if (uri_phase == PH_PREFIX || uri_phase == PH_REJECT)
                status = 1'b1;
            else if (uri_phase == PH_DRIVE)
            begin
                expect_byte(CH_SLASH);
                spill_look();
            end
            else if (uri_phase == PH_BODY)
                spill_look();
            expect_res(8'h00, 1'b0, 1'b1, status);
            uris_closed++;
            if (status)
                uris_rejected++;
            clear_uri_state();
        end
        else
        begin
            case (uri_phase)
                PH_PREFIX:
                begin
                    if (scheme_pos < PREFIX_LEN && b == scheme_str[scheme_pos])
                    begin
                        scheme_pos++;
                        if (scheme_pos == PREFIX_LEN)
                            uri_phase = PH_AUTH;
                    end
                    else
                        uri_phase = PH_REJECT;
                end
                PH_AUTH:
                begin
                    if (b == CH_SLASH)
                    begin
                        uri_phase = PH_DRIVE;
                        look_n    = 0;
                    end
                end
                PH_DRIVE:
                begin
                    if (look_n < 3)
                    begin
                        look[look_n] = b;
                        look_n++;
                    end
                    // drive root: letter then ':' or "%3"
                    if (!alpha(look[0]))
                    begin
                        decided    = 1'b1;
                        keep_slash = 1'b1;
                    end
                    else if (look_n >= 2)
                    begin
                        if (look[1] == CH_COLON)
                            decided = 1'b1;
                        else if (look[1] != CH_PCT)
                        begin
                            decided    = 1'b1;
                            keep_slash = 1'b1;
                        end
                        else if (look_n >= 3)
                        begin
                            decided    = 1'b1;
                            keep_slash = (look[2] != CH_THREE);
                        end
                    end
                    if (decided)
                    begin
                        if (keep_slash)
                            expect_byte(CH_SLASH);
                        uri_phase = PH_BODY;
                        settle_look();
                    end
                end
                PH_BODY:
                begin
                    if (look_n < 3)
                    begin
                        look[look_n] = b;
                        look_n++;
                    end
                    settle_look();
                end
                default:
                    ;
            endcase
        end
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_item(input logic [7:0] b, input logic close);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= close;
        do
            @(posedge clk);
        while (!s_tready);
        decode_item(b, close);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    task automatic close_uri();
        if ($urandom_range(0, 1))
            send_item(8'($urandom_range(0, 255)), 1'b1);
        else
            send_item(8'h00, 1'b0);
    endtask

    function automatic logic [7:0] body_byte();
        string hexs;
        int    pick;
        hexs = "0123456789abcdefABCDEF";
        pick = $urandom_range(0, 9);
        if (pick < 3)
            return CH_PCT;
        else if (pick < 7)
            return hexs[$urandom_range(0, 21)];
        else if (pick == 7)
            return $urandom_range(0, 1) ? CH_SLASH : CH_COLON;
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic logic [7:0] rand_letter();
        logic [7:0] c;
        c = 8'($urandom_range(0, 25));
        return $urandom_range(0, 1) ? c + "a" : c + "A";
    endfunction

    task automatic test_drive_roots();
        send_text("file://h/C:/a");
        send_item(8'h00, 1'b1);
        send_text("file:///z%3Ab");
        send_item(8'h00, 1'b0);
        send_text("file:///d%41");
        send_item(8'hFF, 1'b1);
    endtask

    task automatic test_escapes();
        // decoded zero, both hex cases, broken escapes, a '%' pending at the close
        send_text("file:///%00%ff%FF%g1%4");
        send_item(8'hFF, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(CH_PCT, 1'b0);
        send_item(8'h00, 1'b1);
    endtask

    task automatic test_closes();
        send_text("http:");
        send_item(8'h00, 1'b0);
        send_text("fil");
        send_item(8'h00, 1'b1);
        send_text("file://au");
        send_item(8'h00, 1'b1);
        send_text("file:///C");
        send_item(8'h00, 1'b1);
        send_text("file:///C%");
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b1);
    endtask

    task automatic test_random_uris();
        int         deep;
        int         kind;
        int         mark;
        int         n;
        logic [7:0] b;
        deep = 0;
        while (deep < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 5) == 0)
                tx_calm = ~tx_calm;
            if ($urandom_range(0, 5) == 0)
                rx_calm = ~rx_calm;
            mark = items_sent;
            kind = $urandom_range(0, 9);
            if (kind <= 6)
            begin
                send_text(scheme_str);
                n = $urandom_range(0, 3);
                repeat (n)
                begin
                    do
                        b = 8'($urandom_range(1, 255));
                    while (b == CH_SLASH);
                    send_item(b, 1'b0);
                end
                send_item(CH_SLASH, 1'b0);
                case ($urandom_range(0, 3))
                    0:
                    begin
                        send_item(rand_letter(), 1'b0);
                        send_item(CH_COLON, 1'b0);
                    end
                    1:
                    begin
                        send_item(rand_letter(), 1'b0);
                        send_item(CH_PCT, 1'b0);
                        send_item(CH_THREE, 1'b0);
                    end
                    2:
                    begin
                        send_item(rand_letter(), 1'b0);
                        send_item(CH_PCT, 1'b0);
                        send_item(body_byte(), 1'b0);
                    end
                    default:
                        ;
                endcase
                n = $urandom_range(0, 10);
                repeat (n)
                    send_item(body_byte(), 1'b0);
            end
            else if (kind == 7)
            begin
                // prefix broken at a random place
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++)
                    send_item(scheme_str[i], 1'b0);
                send_item(8'($urandom_range(1, 255)), 1'b0);
                n = $urandom_range(0, 5);
                repeat (n)
                    send_item(8'($urandom_range(1, 255)), 1'b0);
            end
            else if (kind == 8)
            begin
                // closed early, inside the authority or the drive check
                send_text(scheme_str);
                if ($urandom_range(0, 1))
                    send_item(rand_letter(), 1'b0);
                else
                begin
                    send_item(CH_SLASH, 1'b0);
                    send_item(rand_letter(), 1'b0);
                    if ($urandom_range(0, 1))
                        send_item(CH_PCT, 1'b0);
                end
            end
            else
            begin
                n = $urandom_range(1, 8);
                repeat (n)
                    send_item(8'($urandom_range(1, 255)), 1'b0);
            end
            close_uri();
            deep += items_sent - mark;
        end
    endtask

    // receiver: random stall before each result
    initial
    begin
        int hold;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            hold = rx_calm ? 0 : $urandom_range(0, 12);
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (m_tvalid !== 1'b1);
            @(negedge clk);
        end
    end

    // compare each result item with the oldest expected one
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            results_seen++;
            if (path_q.size() == 0)
            begin
                $display("%0t: unexpected result item: data %h user %b last %b",
                         $time, m_tdata, m_tuser, m_tlast);
                errors++;
            end
            else
            begin
                want = path_q.pop_front();
                if (m_tdata !== want.data)
                begin
                    $display("%0t: out_byte expected %h actual %h", $time, want.data, m_tdata);
                    errors++;
                end
                if (m_tuser[0] !== want.has)
                begin
                    $display("%0t: has_byte expected %b actual %b", $time, want.has, m_tuser[0]);
                    errors++;
                end
                if (m_tlast !== want.last)
                begin
                    $display("%0t: last expected %b actual %b", $time, want.last, m_tlast);
                    errors++;
                end
                if (m_tuser[1] !== want.status)
                begin
                    $display("%0t: status expected %b actual %b", $time, want.status, m_tuser[1]);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid === 1'b1 && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready === 1'b1))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles, %0d results still expected",
                     $time, stall_cycles, path_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = 8'h00;
        s_tlast       = 1'b0;
        errors        = 0;
        items_sent    = 0;
        results_seen  = 0;
        uris_closed   = 0;
        uris_rejected = 0;
        stall_cycles  = 0;
        tx_calm       = 1'b0;
        rx_calm       = 1'b0;
        clear_uri_state();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_drive_roots();
        test_escapes();
        test_closes();
        test_random_uris();
        s_tvalid <= 1'b0;

        while (path_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d items in %0d uris (%0d not file uris), checked %0d result items",
                 items_sent, uris_closed, uris_rejected, results_seen);
        $display("covered drive roots, hex escapes, broken escapes, early closes, random stalls");
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
